/* rtl/core/stscan_pkg.sv */
// ----------------------------------------------------------------------------
// stscan_pkg
// Types, character codes, token kinds and character decode helpers shared by
// the source token scanner modules.
// ----------------------------------------------------------------------------
package stscan_pkg;

  // Default counter widths
  localparam int POS_BITS_DEF  = 32;
  localparam int LINE_BITS_DEF = 32;

  // Most tokens that one source byte can produce, and result queue depth
  localparam int MAX_TOK   = 3;
  localparam int TOKCNT_W  = $clog2(MAX_TOK + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Input word
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start_pos;
    logic [31:0] tok_len;
    logic [31:0] line_no;
    logic        last;
  } out_item_t;

  // Tokens produced by one scan step, lowest index first
  typedef struct packed {
    logic [TOKCNT_W-1:0]        cnt;
    out_item_t [MAX_TOK-1:0]    tok;
  } tok_push_t;

  // Scanner mode
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_NUM_INT,
    MODE_NUM_DOT,
    MODE_NUM_FRAC,
    MODE_OP,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_STR
  } scan_mode_t;

  // Byte classes for a byte seen in idle mode
  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_SPACE,
    CC_NEWLINE,
    CC_SLASH,
    CC_OP,
    CC_QUOTE,
    CC_PUNCT
  } char_class_t;

  // Token kinds
  localparam logic [4:0] K_LPAREN     = 5'd0;
  localparam logic [4:0] K_RPAREN     = 5'd1;
  localparam logic [4:0] K_LBRACE     = 5'd2;
  localparam logic [4:0] K_RBRACE     = 5'd3;
  localparam logic [4:0] K_SEMI       = 5'd4;
  localparam logic [4:0] K_COMMA      = 5'd5;
  localparam logic [4:0] K_DOT        = 5'd6;
  localparam logic [4:0] K_MINUS      = 5'd7;
  localparam logic [4:0] K_PLUS       = 5'd8;
  localparam logic [4:0] K_SLASH      = 5'd9;
  localparam logic [4:0] K_STAR       = 5'd10;
  localparam logic [4:0] K_BANG       = 5'd11;
  localparam logic [4:0] K_NE         = 5'd12;
  localparam logic [4:0] K_ASSIGN     = 5'd13;
  localparam logic [4:0] K_EQ         = 5'd14;
  localparam logic [4:0] K_LT         = 5'd15;
  localparam logic [4:0] K_LE         = 5'd16;
  localparam logic [4:0] K_GT         = 5'd17;
  localparam logic [4:0] K_GE         = 5'd18;
  localparam logic [4:0] K_NUMBER     = 5'd19;
  localparam logic [4:0] K_STRING     = 5'd20;
  localparam logic [4:0] K_END        = 5'd21;
  localparam logic [4:0] K_ERR_UNTERM = 5'd22;
  localparam logic [4:0] K_ERR_CHAR   = 5'd23;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Single-character kind of a held operator byte
  function automatic logic [4:0] op_single(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_BANG: k = K_BANG;
      CH_EQ:   k = K_ASSIGN;
      CH_LT:   k = K_LT;
      default: k = K_GT;
    endcase
    return k;
  endfunction

  // Kind of a byte that is a token by itself; anything unknown is an error
  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_SEMI:   k = K_SEMI;
      CH_COMMA:  k = K_COMMA;
      CH_DOT:    k = K_DOT;
      CH_MINUS:  k = K_MINUS;
      CH_PLUS:   k = K_PLUS;
      CH_STAR:   k = K_STAR;
      default:   k = K_ERR_CHAR;
    endcase
    return k;
  endfunction

  function automatic char_class_t char_class(logic [7:0] c);
    char_class_t cc;
    if (is_digit(c)) begin
      cc = CC_DIGIT;
    end else begin
      unique case (c) inside
        CH_SP, CH_CR, CH_TAB:          cc = CC_SPACE;
        CH_NL:                         cc = CC_NEWLINE;
        CH_SLASH:                      cc = CC_SLASH;
        CH_BANG, CH_EQ, CH_LT, CH_GT:  cc = CC_OP;
        CH_DQUOTE, CH_SQUOTE:          cc = CC_QUOTE;
        default:                       cc = CC_PUNCT;
      endcase
    end
    return cc;
  endfunction

endpackage

/* rtl/core/stscan_lexer.sv */
// ----------------------------------------------------------------------------
// stscan_lexer
// Input register, scanner state and the per-byte scan step. Each accepted
// byte produces zero to three tokens, handed to the result queue at once.
// ----------------------------------------------------------------------------
module stscan_lexer
  import stscan_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      room,
  output tok_push_t push
);

  // Arithmetic width for positions and lengths: at least the 32 result bits
  localparam int CW = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int LW = (LINE_BITS > 32) ? LINE_BITS : 32;

  // Input register
  in_item_t item_r;
  logic     item_vld_r;

  // Scanner state
  scan_mode_t           mode_r, mode_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [POS_BITS-1:0]  tb_r, tb_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 fin_r, fin_nxt;

  logic                 step_fire;
  logic [7:0]           c;
  logic                 end_w;
  char_class_t          cls;
  logic                 to_idle;
  logic [CW-1:0]        p_w, tb_w, len_run, len_dot, len_incl, dot_pos;
  logic [LW-1:0]        line_w;
  logic [31:0]          line32;
  logic [LINE_BITS-1:0] line_inc;

  function automatic out_item_t mk_tok(logic [4:0] kind, logic [CW-1:0] start,
                                       logic [CW-1:0] len, logic [31:0] line);
    out_item_t t;
    t.kind      = kind;
    t.start_pos = start[31:0];
    t.tok_len   = len[31:0];
    t.line_no   = line;
    t.last      = 1'b0;
    return t;
  endfunction

  // Handshake: the step runs when the queue can take a full burst
  assign step_fire = item_vld_r && room;
  assign in_ready  = !item_vld_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // Byte decode and position arithmetic
  assign c        = item_r.ch;
  assign end_w    = item_r.is_end || (c == CH_NUL);
  assign cls      = char_class(c);
  assign p_w      = CW'(pos_r);
  assign tb_w     = CW'(tb_r);
  assign len_run  = p_w - tb_w;
  assign len_dot  = p_w - tb_w - CW'(1);
  assign len_incl = p_w + CW'(1) - tb_w;
  assign dot_pos  = p_w - CW'(1);
  assign line_w   = LW'(line_r);
  assign line32   = line_w[31:0];
  assign line_inc = (line_r == {LINE_BITS{1'b1}}) ? line_r : line_r + LINE_BITS'(1);

  // Does the current byte close the pending token and get scanned from idle
  always_comb begin
    to_idle = 1'b0;
    unique case (mode_r) inside
      MODE_NUM_INT:  to_idle = (c != CH_DOT) && !is_digit(c);
      MODE_NUM_DOT,
      MODE_NUM_FRAC: to_idle = !is_digit(c);
      MODE_OP:       to_idle = (c != CH_EQ);
      MODE_SLASH:    to_idle = (c != CH_SLASH);
      MODE_COMMENT,
      MODE_STR:      to_idle = 1'b0;
      default:       to_idle = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    tb_nxt   = tb_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    fin_nxt  = fin_r;
    if (fin_r) begin
      // stuck at end of input until reset
    end else if (end_w) begin
      mode_nxt = MODE_IDLE;
      fin_nxt  = 1'b1;
    end else begin
      pos_nxt = (pos_r == {POS_BITS{1'b1}}) ? pos_r : pos_r + POS_BITS'(1);
      unique case (mode_r) inside
        MODE_NUM_INT: begin
          if (c == CH_DOT) mode_nxt = MODE_NUM_DOT;
        end
        MODE_NUM_DOT: begin
          if (is_digit(c)) mode_nxt = MODE_NUM_FRAC;
        end
        MODE_OP: begin
          if (c == CH_EQ) mode_nxt = MODE_IDLE;
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) mode_nxt = MODE_COMMENT;
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            line_nxt = line_inc;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STR: begin
          if (c == pend_r) begin
            mode_nxt = MODE_IDLE;
          end else if (c == CH_NL) begin
            line_nxt = line_inc;
          end
        end
        default: begin
        end
      endcase
      // Byte seen from idle
      if (to_idle) begin
        mode_nxt = MODE_IDLE;
        unique case (cls)
          CC_DIGIT: begin
            mode_nxt = MODE_NUM_INT;
            tb_nxt   = pos_r;
          end
          CC_NEWLINE: line_nxt = line_inc;
          CC_SLASH: begin
            mode_nxt = MODE_SLASH;
            tb_nxt   = pos_r;
          end
          CC_OP: begin
            mode_nxt = MODE_OP;
            pend_nxt = c;
            tb_nxt   = pos_r;
          end
          CC_QUOTE: begin
            mode_nxt = MODE_STR;
            pend_nxt = c;
            tb_nxt   = pos_r;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Tokens of this step
  always_comb begin
    out_item_t [MAX_TOK-1:0] toks;
    logic [TOKCNT_W-1:0]     n;
    toks = '0;
    n    = '0;
    if (fin_r) begin
      toks[n] = mk_tok(K_END, p_w, '0, line32);
      n       = n + TOKCNT_W'(1);
    end else if (end_w) begin
      // flush whatever is pending, then end of input
      unique case (mode_r) inside
        MODE_NUM_INT, MODE_NUM_FRAC: begin
          toks[n] = mk_tok(K_NUMBER, tb_w, len_run, line32);
          n       = n + TOKCNT_W'(1);
        end
        MODE_NUM_DOT: begin
          toks[n] = mk_tok(K_NUMBER, tb_w, len_dot, line32);
          n       = n + TOKCNT_W'(1);
          toks[n] = mk_tok(K_DOT, dot_pos, CW'(1), line32);
          n       = n + TOKCNT_W'(1);
        end
        MODE_OP: begin
          toks[n] = mk_tok(op_single(pend_r), tb_w, CW'(1), line32);
          n       = n + TOKCNT_W'(1);
        end
        MODE_SLASH: begin
          toks[n] = mk_tok(K_SLASH, tb_w, CW'(1), line32);
          n       = n + TOKCNT_W'(1);
        end
        MODE_STR: begin
          toks[n] = mk_tok(K_ERR_UNTERM, tb_w, len_run, line32);
          n       = n + TOKCNT_W'(1);
        end
        default: begin
        end
      endcase
      toks[n] = mk_tok(K_END, p_w, '0, line32);
      n       = n + TOKCNT_W'(1);
    end else begin
      unique case (mode_r) inside
        MODE_NUM_INT, MODE_NUM_FRAC: begin
          if (to_idle) begin
            toks[n] = mk_tok(K_NUMBER, tb_w, len_run, line32);
            n       = n + TOKCNT_W'(1);
          end
        end
        MODE_NUM_DOT: begin
          // number ends before the dot, dot stands alone
          if (to_idle) begin
            toks[n] = mk_tok(K_NUMBER, tb_w, len_dot, line32);
            n       = n + TOKCNT_W'(1);
            toks[n] = mk_tok(K_DOT, dot_pos, CW'(1), line32);
            n       = n + TOKCNT_W'(1);
          end
        end
        MODE_OP: begin
          if (to_idle) begin
            toks[n] = mk_tok(op_single(pend_r), tb_w, CW'(1), line32);
          end else begin
            toks[n] = mk_tok(op_single(pend_r) + 5'd1, tb_w, len_incl, line32);
          end
          n = n + TOKCNT_W'(1);
        end
        MODE_SLASH: begin
          if (to_idle) begin
            toks[n] = mk_tok(K_SLASH, tb_w, CW'(1), line32);
            n       = n + TOKCNT_W'(1);
          end
        end
        MODE_STR: begin
          if (c == pend_r) begin
            toks[n] = mk_tok(K_STRING, tb_w, len_incl, line32);
            n       = n + TOKCNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (to_idle && (cls == CC_PUNCT)) begin
        toks[n] = mk_tok(punct_kind(c), p_w, CW'(1), line32);
        n       = n + TOKCNT_W'(1);
      end
    end
    if (n != '0) begin
      toks[n - TOKCNT_W'(1)].last = 1'b1;
    end
    push.tok = toks;
    push.cnt = step_fire ? n : '0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= '0;
      tb_r   <= '0;
      pos_r  <= '0;
      line_r <= LINE_BITS'(1);
      fin_r  <= 1'b0;
    end else if (step_fire) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      tb_r   <= tb_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

/* rtl/core/stscan_tok_queue.sv */
// ----------------------------------------------------------------------------
// stscan_tok_queue
// Small result queue: takes up to three tokens per cycle, hands out one per
// cycle while out_ready is high. Signals room while a full burst still fits.
// ----------------------------------------------------------------------------
module stscan_tok_queue
  import stscan_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tok_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= Q_CNT_W'(Q_DEPTH - MAX_TOK));

  // Token storage, burst written at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOK; i++) begin
      if (TOKCNT_W'(i) < push.cnt) begin
        mem_r[wr_ptr_r + Q_PTR_W'(i)] <= push.tok[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + Q_PTR_W'(pop);
      cnt_r    <= cnt_r + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end
  end

endmodule

/* rtl/core/source_token_scanner_core.sv */
// ----------------------------------------------------------------------------
// source_token_scanner_core
// Single-pass lexical scanner: one source byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per source byte (ch, is_end). A zero byte or is_end
//           ends the input; pending tokens are flushed and an end token
//           follows. Every word after that yields one more end token.
//   out_* : one token per word (kind, start_pos, tok_len, line_no, last);
//           last marks the final token caused by one input word.
//   Path:  a token caused by an accepted byte passes the input register and
//           is written to the result queue once the queue has room;
//           out_valid comes from the registered queue fill count.
//   Throughput: one byte per cycle while each byte yields at most one
//           token and the receiver keeps up. A byte yielding two or three
//           tokens holds the input until the queue has drained, since the
//           result queue drains one token a cycle and takes a new byte only
//           while three slots are free.
//   Reset (rst_n low, synchronous): scanner idle, position 0, line 1,
//           queue empty.
//   Stall: with out_ready low the queue fills and in_ready drops; nothing
//           is lost and the scanner state holds.
// ----------------------------------------------------------------------------
module source_token_scanner_core
  import stscan_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  tok_push_t push;
  logic      room;

  // Scan step
  stscan_lexer #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // Result queue
  stscan_tok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/scan_token_checker.sv */
// ----------------------------------------------------------------------------
// scan_token_checker
// Watches both channels of the source token scanner. Every byte word taken
// by the scanner is run through a local model of the scanner, and the tokens
// it predicts are queued. Every token word taken from the scanner is compared
// field by field with the oldest queued token. Mismatches and the number of
// tokens still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module scan_token_checker
  import stscan_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        tokens_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Model state: mode, held operator or quote byte, token start, counters
  scan_mode_t  st_mode  = MODE_IDLE;
  logic [7:0]  st_held  = '0;
  logic [31:0] st_begin = '0;
  logic [31:0] st_pos   = '0;
  logic [31:0] st_line  = 32'd1;
  logic        st_done  = 1'b0;

  out_item_t tok_q[$];      // tokens predicted, not yet seen
  out_item_t step_toks[$];  // tokens of the byte being scanned
  int        mism_total = 0;

  function automatic void bump_line();
    if (st_line != '1) st_line++;
  endfunction

  function automatic void emit_tok(logic [4:0] k, logic [31:0] start, logic [31:0] len);
    out_item_t t;
    t.kind      = k;
    t.start_pos = start;
    t.tok_len   = len;
    t.line_no   = st_line;
    t.last      = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic logic [4:0] held_op_kind(logic [7:0] c);
    case (c)
      CH_BANG: return K_BANG;
      CH_EQ:   return K_ASSIGN;
      CH_LT:   return K_LT;
      default: return K_GT;
    endcase
  endfunction

  // Byte seen with nothing pending
  function automatic void scan_fresh(logic [7:0] c);
    st_mode = MODE_IDLE;
    if (c >= CH_0 && c <= CH_9) begin
      st_mode  = MODE_NUM_INT;
      st_begin = st_pos;
    end else begin
      case (c)
        CH_SP, CH_CR, CH_TAB: ;
        CH_NL: bump_line();
        CH_SLASH: begin
          st_mode  = MODE_SLASH;
          st_begin = st_pos;
        end
        CH_BANG, CH_EQ, CH_LT, CH_GT: begin
          st_mode  = MODE_OP;
          st_held  = c;
          st_begin = st_pos;
        end
        CH_DQUOTE, CH_SQUOTE: begin
          st_mode  = MODE_STR;
          st_held  = c;
          st_begin = st_pos;
        end
        CH_LPAREN: emit_tok(K_LPAREN, st_pos, 32'd1);
        CH_RPAREN: emit_tok(K_RPAREN, st_pos, 32'd1);
        CH_LBRACE: emit_tok(K_LBRACE, st_pos, 32'd1);
        CH_RBRACE: emit_tok(K_RBRACE, st_pos, 32'd1);
        CH_SEMI:   emit_tok(K_SEMI, st_pos, 32'd1);
        CH_COMMA:  emit_tok(K_COMMA, st_pos, 32'd1);
        CH_DOT:    emit_tok(K_DOT, st_pos, 32'd1);
        CH_MINUS:  emit_tok(K_MINUS, st_pos, 32'd1);
        CH_PLUS:   emit_tok(K_PLUS, st_pos, 32'd1);
        CH_STAR:   emit_tok(K_STAR, st_pos, 32'd1);
        default:   emit_tok(K_ERR_CHAR, st_pos, 32'd1);
      endcase
    end
  endfunction

  // One byte word: update the model and queue the tokens it causes
  function automatic void scan_step(in_item_t w);
    logic [7:0]  c;
    logic        stop;
    logic        dig;
    logic [31:0] p;
    out_item_t   t;
    c    = w.ch;
    stop = w.is_end || (c == CH_NUL);
    dig  = (c >= CH_0) && (c <= CH_9);
    p    = st_pos;
    step_toks.delete();
    if (st_done) begin
      emit_tok(K_END, p, 32'd0);
    end else if (stop) begin
      // flush whatever is pending, then the end token
      case (st_mode)
        MODE_NUM_INT, MODE_NUM_FRAC: emit_tok(K_NUMBER, st_begin, p - st_begin);
        MODE_NUM_DOT: begin
          emit_tok(K_NUMBER, st_begin, p - 32'd1 - st_begin);
          emit_tok(K_DOT, p - 32'd1, 32'd1);
        end
        MODE_OP:    emit_tok(held_op_kind(st_held), st_begin, 32'd1);
        MODE_SLASH: emit_tok(K_SLASH, st_begin, 32'd1);
        MODE_STR:   emit_tok(K_ERR_UNTERM, st_begin, p - st_begin);
        default: ;
      endcase
      emit_tok(K_END, p, 32'd0);
      st_mode = MODE_IDLE;
      st_done = 1'b1;
    end else begin
      case (st_mode)
        MODE_NUM_INT: begin
          if (c == CH_DOT) begin
            st_mode = MODE_NUM_DOT;
          end else if (!dig) begin
            emit_tok(K_NUMBER, st_begin, p - st_begin);
            scan_fresh(c);
          end
        end
        MODE_NUM_DOT: begin
          // a dot not followed by a digit belongs to no number
          if (dig) begin
            st_mode = MODE_NUM_FRAC;
          end else begin
            emit_tok(K_NUMBER, st_begin, p - 32'd1 - st_begin);
            emit_tok(K_DOT, p - 32'd1, 32'd1);
            scan_fresh(c);
          end
        end
        MODE_NUM_FRAC: begin
          if (!dig) begin
            emit_tok(K_NUMBER, st_begin, p - st_begin);
            scan_fresh(c);
          end
        end
        MODE_OP: begin
          if (c == CH_EQ) begin
            emit_tok(held_op_kind(st_held) + 5'd1, st_begin, p + 32'd1 - st_begin);
            st_mode = MODE_IDLE;
          end else begin
            emit_tok(held_op_kind(st_held), st_begin, 32'd1);
            scan_fresh(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            st_mode = MODE_COMMENT;
          end else begin
            emit_tok(K_SLASH, st_begin, 32'd1);
            scan_fresh(c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            bump_line();
            st_mode = MODE_IDLE;
          end
        end
        MODE_STR: begin
          if (c == st_held) begin
            emit_tok(K_STRING, st_begin, p + 32'd1 - st_begin);
            st_mode = MODE_IDLE;
          end else if (c == CH_NL) begin
            bump_line();
          end
        end
        default: scan_fresh(c);
      endcase
      if (st_pos != '1) st_pos++;
    end
    foreach (step_toks[i]) begin
      t      = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      tok_q.push_back(t);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mism_total++;
    end
  endfunction

  // Compare taken tokens first: a byte taken at this edge cannot have caused them
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      st_mode  = MODE_IDLE;
      st_held  = '0;
      st_begin = '0;
      st_pos   = '0;
      st_line  = 32'd1;
      st_done  = 1'b0;
      tok_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tok_q.size() == 0) begin
          $error("token with nothing expected: kind %0d start_pos %0d",
                 out_data.kind, out_data.start_pos);
          mism_total++;
        end else begin
          want = tok_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("start_pos", want.start_pos, out_data.start_pos);
          check_field("tok_len", want.tok_len, out_data.tok_len);
          check_field("line_no", want.line_no, out_data.line_no);
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (in_valid && in_ready) scan_step(in_data);
    end
    mismatches  <= mism_total;
    tokens_owed <= tok_q.size();
  end

endmodule

/* bench/source_token_scanner_core_tb.sv */
// ----------------------------------------------------------------------------
// source_token_scanner_core_tb
// Feeds the scanner one source stream: a short hand-written opening with all
// punctuation and every operator but a lone > and =, then random well-formed
// tokens (numbers, strings, comments, operators) mixed with blanks and stray
// bytes, then mostly a pending token cut off by the end word and a few words
// after the end. Both sides stall at random; the receiver also holds off for
// a long stretch so the result queue fills. A checker beside the scanner
// predicts and compares every token.
// ----------------------------------------------------------------------------
module source_token_scanner_core_tb
  import stscan_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_START  = 150;  // receiver hold-off, cycles after reset
  localparam int HOLD_CYCLES = 80;
  localparam int CALM_START  = 450;  // receiver never stalls in this window
  localparam int CALM_CYCLES = 200;
  localparam int BUSY_FIRST  = 200;  // sender never idles for these words
  localparam int BUSY_LAST   = 330;

  localparam logic [7:0] PUNCT_CH [10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                           CH_SEMI, CH_COMMA, CH_DOT, CH_MINUS, CH_PLUS,
                                           CH_STAR};
  localparam logic [7:0] OP_CH [4]    = '{CH_BANG, CH_EQ, CH_LT, CH_GT};
  localparam logic [7:0] BLANK_CH [4] = '{CH_SP, CH_TAB, CH_CR, CH_NL};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  int        mismatches;
  int        tokens_owed;

  in_item_t src_q[$];  // whole source stream, in order

  source_token_scanner_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  scan_token_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .tokens_owed (tokens_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void put_word(logic [7:0] c, logic e);
    in_item_t w;
    w.ch     = c;
    w.is_end = e;
    src_q.push_back(w);
  endfunction

  function automatic void put_byte(logic [7:0] c);
    put_word(c, 1'b0);
  endfunction

  // Nonzero byte other than the one given
  function automatic logic [7:0] any_byte_but(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == avoid);
    return c;
  endfunction

  // One random token, mostly well formed, sometimes followed by a blank
  function automatic void put_random_token();
    int         pick;
    logic [7:0] q;
    pick = $urandom_range(99);
    if (pick < 12) begin
      put_byte(PUNCT_CH[$urandom_range(9)]);
    end else if (pick < 24) begin
      put_byte(OP_CH[$urandom_range(3)]);
      if ($urandom_range(1) == 1) put_byte(CH_EQ);
    end else if (pick < 44) begin
      repeat ($urandom_range(4, 1)) put_byte(CH_0 + 8'($urandom_range(9)));
      if ($urandom_range(9) < 3) begin
        put_byte(CH_DOT);
        repeat ($urandom_range(3)) put_byte(CH_0 + 8'($urandom_range(9)));
      end
    end else if (pick < 58) begin
      q = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
      put_byte(q);
      repeat ($urandom_range(5)) put_byte(($urandom_range(9) == 0) ? CH_NL : any_byte_but(q));
      put_byte(q);
    end else if (pick < 66) begin
      put_byte(CH_SLASH);
      put_byte(CH_SLASH);
      repeat ($urandom_range(6)) put_byte(any_byte_but(CH_NL));
      put_byte(CH_NL);
    end else if (pick < 70) begin
      put_byte(CH_SLASH);
    end else if (pick < 88) begin
      put_byte(BLANK_CH[$urandom_range(3)]);
    end else begin
      put_byte(any_byte_but(CH_NUL));
    end
    if ($urandom_range(1) == 1) put_byte(BLANK_CH[$urandom_range(3)]);
  endfunction

  // Receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int cyc;
    cyc = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else if (cyc >= CALM_START && cyc < CALM_START + CALM_CYCLES) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 37);
      end
      @(posedge clk);
      cyc++;
    end
  end

  // Stimulus and verdict
  initial begin
    int         idx;
    int         wait_cyc;
    int         tail;
    logic [7:0] c;
    string      intro;
    intro = "(){};,.-+*!=!<=<>=>===9.5/3.x@";
    for (idx = 0; idx < intro.len(); idx++) put_byte(intro[idx]);
    while (src_q.size() < intro.len() + 415) put_random_token();

    // mostly leave something pending for the end word to flush
    tail = $urandom_range(9);
    if (tail < 5) begin
      // unterminated string across a line break
      put_byte(CH_SQUOTE);
      put_byte(any_byte_but(CH_SQUOTE));
      put_byte(CH_NL);
    end else begin
      case (tail)
        5: begin
          put_byte(CH_0 + 8'd4);
          put_byte(CH_0 + 8'd2);
        end
        6: begin
          put_byte(CH_0 + 8'd7);
          put_byte(CH_DOT);
        end
        7: put_byte(CH_LT);
        8: put_byte(CH_SLASH);
        default: ;
      endcase
    end

    // end word: zero byte or end flag, then words after the end
    c = ($urandom_range(1) == 1) ? CH_NUL : 8'($urandom_range(255));
    put_word(c, (c != CH_NUL) ? 1'b1 : 1'($urandom_range(1)));
    put_word(CH_NUL, 1'b1);
    put_word(8'($urandom_range(255)), 1'b1);
    put_word(any_byte_but(CH_NUL), 1'b0);
    put_word(CH_NUL, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < src_q.size(); idx++) begin
      if (idx < BUSY_FIRST || idx >= BUSY_LAST) begin
        while ($urandom_range(99) < 37) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_data  <= src_q[idx];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;

    // let the checker see the last word, then drain
    @(posedge clk);
    for (wait_cyc = 0; wait_cyc < 20000 && tokens_owed != 0; wait_cyc++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tokens_owed != 0) $error("%0d expected tokens never arrived", tokens_owed);
    if (mismatches == 0 && tokens_owed == 0) begin
      $display("source_token_scanner_core_tb: done, clean");
    end else begin
      $display("source_token_scanner_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("source_token_scanner_core_tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/stscan_pkg.sv
rtl/core/stscan_lexer.sv
rtl/core/stscan_tok_queue.sv
rtl/core/source_token_scanner_core.sv
bench/scan_token_checker.sv
bench/source_token_scanner_core_tb.sv
